@@ rtl/lmp_pkg.sv @@
// Shared constants, types and the CORDIC angle table for the lm to lon/lat projection.
// Depends on nothing; every other file in rtl uses it.

package lmp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q             = 30;
    localparam int ITER          = 30;
    localparam int SQRT_STEPS    = 31;

    localparam logic signed [39:0] INV_GAIN  = 40'sd652032874;
    localparam logic signed [39:0] PI_Q      = 40'sd3373259426;
    localparam logic signed [39:0] HALF_PI_Q = 40'sd1686629713;
    localparam logic signed [39:0] TWO_PI_Q  = 40'sd6746518852;

    // register indexes on the APB port
    localparam logic REG_LON = 1'b0;
    localparam logic REG_LAT = 1'b1;

    typedef struct packed {
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
    } trig_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [35:0] atan_step(input logic [4:0] idx);
        logic signed [35:0] val;
        unique case (idx)
            5'd0:    val = 36'sd843314856;
            5'd1:    val = 36'sd497837829;
            5'd2:    val = 36'sd263043836;
            5'd3:    val = 36'sd133525158;
            5'd4:    val = 36'sd67021686;
            5'd5:    val = 36'sd33543515;
            5'd6:    val = 36'sd16775850;
            5'd7:    val = 36'sd8388437;
            5'd8:    val = 36'sd4194282;
            5'd9:    val = 36'sd2097149;
            default: val = (36'sd1 <<< (6'd30 - {1'b0, idx})) - 36'sd1;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/lm_to_lon_lat_projection.sv @@
// Top level: inverse orthographic projection of direction cosines (l, m) to lon/lat.
// Depends on lmp_pkg, lmp_sincos, lmp_isqrt and lmp_atan2.
//
// Usage:
//   Input channel in_valid/in_ready carries dir_l, dir_m (signed, FRAC_BITS fraction
//   bits) and last_in. Output channel out_valid/out_ready carries longitude_out,
//   latitude_out (radians, FRAC_BITS fraction bits), outside_flag and last_out.
//   Every request gives exactly one result, in order. Points with l^2 + m^2 > 1
//   come out with outside_flag set and zero angles.
//   The stages are: input register, 31-stage square root for n, three
//   product/round stages, 31-stage square root for the asin cosine, one fold
//   stage plus 30 CORDIC stages for both atan2 units, and the output register.
//   Throughput is one request per cycle unless the output or the lat0 CORDIC stalls.
//   The centre (lon0, lat0) is set over APB at byte addresses 0 and 4. sin and
//   cos of lat0 come from a sequential CORDIC that runs after reset and after each
//   latitude write; in_ready stays low while it runs.
//   Reset clears the centre to zero and empties the pipeline.
//   When out_ready is low with a result waiting, the whole pipeline holds; nothing
//   is dropped or repeated. Bubbles are not squeezed out during a stall.

module lm_to_lon_lat_projection #(
    parameter int FRAC_BITS = lmp_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [17:0] dir_l,
    input  logic signed [17:0] dir_m,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] longitude_out,
    output logic signed [17:0] latitude_out,
    output logic               outside_flag,
    output logic               last_out
);

    localparam int SH = lmp_pkg::Q - FRAC_BITS;
    localparam logic signed [39:0] LIM   = 40'sd1 <<< (FRAC_BITS + 1);
    localparam logic [63:0]        ONE2F = 64'd1 << (2 * FRAC_BITS);
    localparam logic [63:0]        ONE60 = 64'd1 << 60;
    localparam logic signed [64:0] RND   = 65'sd1 <<< (lmp_pkg::Q - 1);
    localparam logic signed [43:0] HALF  = (SH > 0) ? (44'sd1 <<< (SH - 1)) : 44'sd0;
    localparam int S1_SIDE = 66;
    localparam int S2_SIDE = 102;

    // configuration
    logic [18:0]    lon_cfg_reg;
    logic [17:0]    lat_cfg_reg;
    logic           cfg_wr;
    logic           lat_start;
    logic           trig_busy;
    lmp_pkg::trig_t trig;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign lat_start = cfg_wr && (paddr[2] == lmp_pkg::REG_LAT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_cfg_reg <= '0;
            lat_cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                lmp_pkg::REG_LON: lon_cfg_reg <= pwdata[18:0];
                lmp_pkg::REG_LAT: lat_cfg_reg <= pwdata[17:0];
                default:          lon_cfg_reg <= lon_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lmp_pkg::REG_LON: prdata = {13'd0, lon_cfg_reg};
            lmp_pkg::REG_LAT: prdata = {14'd0, lat_cfg_reg};
            default:          prdata = '0;
        endcase
    end

    lmp_sincos #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sincos (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lat_start),
        .angle (signed'(lat_cfg_reg)),
        .busy  (trig_busy),
        .trig  (trig)
    );

    // pipeline advance
    logic en;
    logic out_valid_reg;

    assign en       = out_ready || !out_valid_reg;
    assign in_ready = en && !trig_busy;

    // stage 1: clamp, squares, widen to Q30
    logic signed [39:0] dl_w, dm_w;
    logic signed [18:0] lc, mc;
    logic signed [37:0] lsq, msq;
    logic               s1_val_reg, s1_last_reg;
    logic signed [31:0] s1_l_reg, s1_m_reg;
    logic [35:0]        s1_ssum_reg;

    always_comb
    begin
        dl_w = 40'(dir_l);
        dm_w = 40'(dir_m);
        if (dl_w > LIM)
        begin
            lc = 19'(LIM);
        end
        else if (dl_w < -LIM)
        begin
            lc = 19'(-LIM);
        end
        else
        begin
            lc = 19'(dl_w);
        end
        if (dm_w > LIM)
        begin
            mc = 19'(LIM);
        end
        else if (dm_w < -LIM)
        begin
            mc = 19'(-LIM);
        end
        else
        begin
            mc = 19'(dm_w);
        end
        lsq = lc * lc;
        msq = mc * mc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_val_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_val_reg <= in_valid && in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_l_reg    <= 32'(40'(lc) <<< SH);
            s1_m_reg    <= 32'(40'(mc) <<< SH);
            s1_ssum_reg <= 36'(lsq) + 36'(msq);
            s1_last_reg <= last_in;
        end
    end

    // radicand 1 - l^2 - m^2 in Q60
    logic               s1_outside;
    logic [63:0]        rad1_w;
    logic [60:0]        rad1;

    assign s1_outside = {28'd0, s1_ssum_reg} > ONE2F;
    assign rad1_w     = (ONE2F - {28'd0, s1_ssum_reg}) << (60 - 2 * FRAC_BITS);
    assign rad1       = s1_outside ? 61'd0 : rad1_w[60:0];

    logic               q1_val;
    logic [30:0]        n_root;
    logic [S1_SIDE-1:0] q1_side;

    lmp_isqrt #(
        .SIDE_W (S1_SIDE)
    ) u_sqrt_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_val_reg),
        .rad       (rad1),
        .side_in   ({s1_l_reg, s1_m_reg, s1_outside, s1_last_reg}),
        .out_valid (q1_val),
        .root      (n_root),
        .side_out  (q1_side)
    );

    // P1: the four products
    logic signed [31:0] n_s, q1_m;
    logic               p1_val_reg, p1_out_reg, p1_last_reg;
    logic signed [31:0] p1_l_reg;
    logic signed [63:0] p_ns_reg, p_mc_reg, p_nc_reg, p_ms_reg;

    assign n_s  = signed'({1'b0, n_root});
    assign q1_m = signed'(q1_side[33:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_val_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_val_reg <= q1_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ns_reg    <= n_s * trig.sin_v;
            p_mc_reg    <= q1_m * trig.cos_v;
            p_nc_reg    <= n_s * trig.cos_v;
            p_ms_reg    <= q1_m * trig.sin_v;
            p1_l_reg    <= signed'(q1_side[65:34]);
            p1_out_reg  <= q1_side[1];
            p1_last_reg <= q1_side[0];
        end
    end

    // P2: sums rounded back to Q30, asin argument clamped to [-1, 1]
    logic signed [64:0] sum_v, sum_d;
    logic signed [34:0] v_rnd, d_rnd;
    logic signed [31:0] v_clamped;
    logic               p2_val_reg, p2_out_reg, p2_last_reg;
    logic signed [31:0] p2_l_reg, p2_v_reg;
    logic signed [35:0] p2_d_reg;

    assign sum_v = 65'(p_ns_reg) + 65'(p_mc_reg) + RND;
    assign sum_d = 65'(p_nc_reg) - 65'(p_ms_reg) + RND;
    assign v_rnd = 35'(sum_v >>> lmp_pkg::Q);
    assign d_rnd = 35'(sum_d >>> lmp_pkg::Q);

    always_comb
    begin
        if (v_rnd > 35'sd1073741824)
        begin
            v_clamped = 32'sd1073741824;
        end
        else if (v_rnd < -35'sd1073741824)
        begin
            v_clamped = -32'sd1073741824;
        end
        else
        begin
            v_clamped = 32'(v_rnd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_val_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_val_reg <= p1_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_v_reg    <= v_clamped;
            p2_d_reg    <= 36'(d_rnd);
            p2_l_reg    <= p1_l_reg;
            p2_out_reg  <= p1_out_reg;
            p2_last_reg <= p1_last_reg;
        end
    end

    // P3: v squared
    logic               p3_val_reg, p3_out_reg, p3_last_reg;
    logic signed [31:0] p3_l_reg, p3_v_reg;
    logic signed [35:0] p3_d_reg;
    logic signed [63:0] p3_vv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_val_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_val_reg <= p2_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_vv_reg   <= p2_v_reg * p2_v_reg;
            p3_v_reg    <= p2_v_reg;
            p3_d_reg    <= p2_d_reg;
            p3_l_reg    <= p2_l_reg;
            p3_out_reg  <= p2_out_reg;
            p3_last_reg <= p2_last_reg;
        end
    end

    logic [63:0]        rad2_w;
    logic               q2_val;
    logic [30:0]        s_root;
    logic [S2_SIDE-1:0] q2_side;

    assign rad2_w = ONE60 - unsigned'(p3_vv_reg);

    lmp_isqrt #(
        .SIDE_W (S2_SIDE)
    ) u_sqrt_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p3_val_reg),
        .rad       (rad2_w[60:0]),
        .side_in   ({p3_v_reg, p3_d_reg, p3_l_reg, p3_out_reg, p3_last_reg}),
        .out_valid (q2_val),
        .root      (s_root),
        .side_out  (q2_side)
    );

    // latitude = atan2(v, s), longitude offset = atan2(l, d)
    logic signed [35:0] lat_y, lat_x, lon_y, lon_x;
    logic               lat_val, lon_val;
    logic signed [35:0] lat_z, lon_z;
    logic               a_last, a_out;

    assign lat_y = 36'(signed'(q2_side[101:70]));
    assign lat_x = signed'({5'd0, s_root});
    assign lon_x = signed'(q2_side[69:34]);
    assign lon_y = 36'(signed'(q2_side[33:2]));

    lmp_atan2 #(
        .SIDE_W (1)
    ) u_atan_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q2_val),
        .y_in      (lat_y),
        .x_in      (lat_x),
        .side_in   (q2_side[0]),
        .out_valid (lat_val),
        .angle     (lat_z),
        .side_out  (a_last)
    );

    lmp_atan2 #(
        .SIDE_W (1)
    ) u_atan_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q2_val),
        .y_in      (lon_y),
        .x_in      (lon_x),
        .side_in   (q2_side[1]),
        .out_valid (lon_val),
        .angle     (lon_z),
        .side_out  (a_out)
    );

    // output: round to FRAC_BITS and saturate
    logic signed [43:0] lon_sum, lon_r, lat_r;
    logic signed [19:0] lon_sat;
    logic signed [17:0] lat_sat;
    logic signed [19:0] lon_reg;
    logic signed [17:0] lat_reg;
    logic               outside_reg, last_reg;

    assign lon_sum = (44'(signed'(lon_cfg_reg)) <<< SH) + 44'(lon_z);
    assign lon_r   = (lon_sum + HALF) >>> SH;
    assign lat_r   = (44'(lat_z) + HALF) >>> SH;

    always_comb
    begin
        if (lon_r > 44'sd524287)
        begin
            lon_sat = 20'sd524287;
        end
        else if (lon_r < -44'sd524288)
        begin
            lon_sat = -20'sd524288;
        end
        else
        begin
            lon_sat = 20'(lon_r);
        end
        if (lat_r > 44'sd131071)
        begin
            lat_sat = 18'sd131071;
        end
        else if (lat_r < -44'sd131072)
        begin
            lat_sat = -18'sd131072;
        end
        else
        begin
            lat_sat = 18'(lat_r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= lat_val && lon_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lon_reg     <= a_out ? 20'sd0 : lon_sat;
            lat_reg     <= a_out ? 18'sd0 : lat_sat;
            outside_reg <= a_out;
            last_reg    <= a_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign longitude_out = lon_reg;
    assign latitude_out  = lat_reg;
    assign outside_flag  = outside_reg;
    assign last_out      = last_reg;

endmodule

@@ rtl/lmp_sincos.sv @@
// Sequential rotation CORDIC: sine and cosine of the centre latitude.
// Runs after reset and after every latitude write. Uses lmp_pkg.

module lmp_sincos #(
    parameter int FRAC_BITS = lmp_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [17:0]  angle,
    output logic                busy,
    output lmp_pkg::trig_t      trig
);

    localparam int SH = lmp_pkg::Q - FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_ROTATE = 4'b1000
    } state_t;

    state_t             state_reg;
    logic signed [39:0] r_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [4:0]         i_reg;
    logic               neg_reg;
    lmp_pkg::trig_t     trig_reg;

    logic signed [39:0] fold;
    logic               fold_neg;
    logic               in_range;
    logic signed [33:0] dx, dy, at, x_next, y_next, z_next;
    logic               last_iter;

    always_comb
    begin
        fold     = r_reg;
        fold_neg = 1'b0;
        if (fold > lmp_pkg::PI_Q)
        begin
            fold = fold - lmp_pkg::TWO_PI_Q;
        end
        else if (fold < -lmp_pkg::PI_Q)
        begin
            fold = fold + lmp_pkg::TWO_PI_Q;
        end
        if (fold > lmp_pkg::HALF_PI_Q)
        begin
            fold     = fold - lmp_pkg::PI_Q;
            fold_neg = 1'b1;
        end
        else if (fold < -lmp_pkg::HALF_PI_Q)
        begin
            fold     = fold + lmp_pkg::PI_Q;
            fold_neg = 1'b1;
        end
    end

    assign in_range  = (r_reg < lmp_pkg::TWO_PI_Q) && (r_reg > -lmp_pkg::TWO_PI_Q);
    assign last_iter = (i_reg == 5'(lmp_pkg::ITER - 1));

    always_comb
    begin
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        at = 34'(lmp_pkg::atan_step(i_reg));
        if (z_reg >= 0)
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else if (start)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:   state_reg <= ST_REDUCE;
                ST_REDUCE: if (in_range) state_reg <= ST_ROTATE;
                ST_ROTATE: if (last_iter) state_reg <= ST_IDLE;
                ST_IDLE:   state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:
            begin
                r_reg <= 40'(angle) <<< SH;
            end
            ST_REDUCE:
            begin
                // same as a truncating modulo by two pi
                if (r_reg >= lmp_pkg::TWO_PI_Q)
                begin
                    r_reg <= r_reg - lmp_pkg::TWO_PI_Q;
                end
                else if (r_reg <= -lmp_pkg::TWO_PI_Q)
                begin
                    r_reg <= r_reg + lmp_pkg::TWO_PI_Q;
                end
                else
                begin
                    z_reg   <= 34'(fold);
                    x_reg   <= 34'(lmp_pkg::INV_GAIN);
                    y_reg   <= '0;
                    i_reg   <= '0;
                    neg_reg <= fold_neg;
                end
            end
            ST_ROTATE:
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                i_reg <= i_reg + 5'd1;
                if (last_iter)
                begin
                    trig_reg.sin_v <= neg_reg ? 32'(-y_next) : 32'(y_next);
                    trig_reg.cos_v <= neg_reg ? 32'(-x_next) : 32'(x_next);
                end
            end
            ST_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign trig = trig_reg;

endmodule

@@ rtl/lmp_isqrt.sv @@
// Pipelined integer square root of a 61-bit value, one result bit per stage.
// Carries a sideband word alongside. Uses lmp_pkg.

module lmp_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [60:0]       rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [30:0]       root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STEPS = lmp_pkg::SQRT_STEPS;

    logic [61:0]       v_reg    [STEPS];
    logic [61:0]       res_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [STEPS-1:0]  val_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [61:0]       v_i, r_i, t;
        logic [SIDE_W-1:0] s_i;
        logic              val_i;
        localparam logic [61:0] BIT_K = 62'(1) << (60 - 2 * k);

        if (k == 0)
        begin : g_first
            assign v_i   = {1'b0, rad};
            assign r_i   = '0;
            assign s_i   = side_in;
            assign val_i = in_valid;
        end
        else
        begin : g_next
            assign v_i   = v_reg[k-1];
            assign r_i   = res_reg[k-1];
            assign s_i   = side_reg[k-1];
            assign val_i = val_reg[k-1];
        end

        assign t = r_i + BIT_K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[k] <= val_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= s_i;
                if (v_i >= t)
                begin
                    v_reg[k]   <= v_i - t;
                    res_reg[k] <= (r_i >> 1) + BIT_K;
                end
                else
                begin
                    v_reg[k]   <= v_i;
                    res_reg[k] <= r_i >> 1;
                end
            end
        end
    end

    assign out_valid = val_reg[STEPS-1];
    assign root      = res_reg[STEPS-1][30:0];
    assign side_out  = side_reg[STEPS-1];

endmodule

@@ rtl/lmp_atan2.sv @@
// Pipelined vectoring CORDIC atan2(y, x) in Q30, one iteration per stage.
// Carries a sideband word alongside. Uses lmp_pkg.

module lmp_atan2 #(
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [35:0] y_in,
    input  logic signed [35:0] x_in,
    input  logic [SIDE_W-1:0]  side_in,
    output logic               out_valid,
    output logic signed [35:0] angle,
    output logic [SIDE_W-1:0]  side_out
);

    localparam int ITER = lmp_pkg::ITER;

    logic signed [37:0] x_reg    [ITER+1];
    logic signed [37:0] y_reg    [ITER+1];
    logic signed [35:0] z_reg    [ITER+1];
    logic               zero_reg [ITER+1];
    logic [SIDE_W-1:0]  side_reg [ITER+1];
    logic [ITER:0]      val_reg;

    // front stage: fold the left half plane over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            val_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            zero_reg[0] <= (x_in == 36'sd0) && (y_in == 36'sd0);
            if (x_in < 0)
            begin
                x_reg[0] <= -38'(x_in);
                y_reg[0] <= -38'(y_in);
                z_reg[0] <= (y_in >= 0) ? 36'(lmp_pkg::PI_Q) : -36'(lmp_pkg::PI_Q);
            end
            else
            begin
                x_reg[0] <= 38'(x_in);
                y_reg[0] <= 38'(y_in);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < ITER; k++)
    begin : g_step
        logic signed [37:0] dx, dy;
        localparam logic signed [35:0] AT = lmp_pkg::atan_step(5'(k));

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[k+1] <= val_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                if (y_reg[k] >= 0)
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + AT;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - AT;
                end
            end
        end
    end

    assign out_valid = val_reg[ITER];
    assign angle     = zero_reg[ITER] ? 36'sd0 : z_reg[ITER];
    assign side_out  = side_reg[ITER];

endmodule

@@ tb/tb_lm_to_lon_lat_projection.sv @@
// Self-checking testbench for lm_to_lon_lat_projection: random and directed (l, m) requests,
// centre settings over APB, results checked in order against a bit-exact predictor.
// Depends on rtl/lmp_pkg.sv and the block's RTL.
`timescale 1ns / 1ps

typedef struct {
    logic signed [19:0] lon;
    logic signed [17:0] lat;
    logic               outside;
    logic               last;
} sky_pos_t;

class sky_scoreboard;
    localparam longint TWO_PI  = 64'sd6746518852;
    localparam longint PI_V    = 64'sd3373259426;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint ONE_Q   = 64'sd1 << 30;

    logic [18:0] centre_lon;
    logic [17:0] centre_lat;
    sky_pos_t    pending[$];
    int          errors;
    longint      angle_tab[10];

    function new();
        centre_lon = '0;
        centre_lat = '0;
        errors = 0;
        angle_tab = '{843314856, 497837829, 263043836, 133525158, 67021686,
                      33543515, 16775850, 8388437, 4194282, 2097149};
    endfunction

    function longint angle_of(int i);
        if (i < 10)
            return angle_tab[i];
        return (64'sd1 << (30 - i)) - 1;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint round_q60(longint p);
        return (p + (64'sd1 << 29)) >>> 30;
    endfunction

    function void rotate(longint a, output longint s, output longint c);
        longint x, y, z, r, dx, dy;
        bit neg;
        x = 652032874;
        y = 0;
        neg = 0;
        r = a % TWO_PI;
        if (r > PI_V) r -= TWO_PI;
        if (r < -PI_V) r += TWO_PI;
        if (r > HALF_PI) begin r -= PI_V; neg = 1; end
        else if (r < -HALF_PI) begin r += PI_V; neg = 1; end
        z = r;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= angle_of(i); end
            else begin x += dx; y -= dy; z += angle_of(i); end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_V : -PI_V;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin x += dx; y -= dy; z += angle_of(i); end
            else begin x -= dx; y += dy; z -= angle_of(i); end
        end
        return z;
    endfunction

    function longint to_field(longint v, int w);
        longint lim;
        lim = 64'sd1 << (w - 1);
        return clampl((v + (64'sd1 << 13)) >>> 14, -lim, lim - 1);
    endfunction

    function void set_centre(bit is_lat, logic [31:0] value);
        if (is_lat)
            centre_lat = value[17:0];
        else
            centre_lon = value[18:0];
    endfunction

    function void note_request(logic signed [17:0] dl, logic signed [17:0] dm, logic lst);
        longint l, m, n, s0, c0, v, d, sq, lon0;
        longint unsigned ul, um, r2;
        sky_pos_t e;
        l = clampl(longint'(dl) * 16384, -(64'sd1 << 31), 64'sd1 << 31);
        m = clampl(longint'(dm) * 16384, -(64'sd1 << 31), 64'sd1 << 31);
        ul = l < 0 ? -l : l;
        um = m < 0 ? -m : m;
        r2 = ul * ul + um * um;
        e.lon = '0;
        e.lat = '0;
        e.outside = 0;
        e.last = lst;
        if (r2 > (64'd1 << 60)) begin
            e.outside = 1;
        end else begin
            n = int_sqrt((64'd1 << 60) - r2);
            lon0 = longint'($signed(centre_lon)) * 16384;
            rotate(longint'($signed(centre_lat)) * 16384, s0, c0);
            v = clampl(round_q60(n * s0 + m * c0), -ONE_Q, ONE_Q);
            d = round_q60(n * c0 - m * s0);
            sq = int_sqrt((64'd1 << 60) - longint'(v * v));
            e.lat = 18'(to_field(vector_angle(v, sq), 18));
            e.lon = 20'(to_field(lon0 + vector_angle(l, d), 20));
        end
        pending.push_back(e);
    endfunction

    function void check_result(logic signed [19:0] lon, logic signed [17:0] lat,
                               logic outside, logic lst);
        sky_pos_t e;
        if (pending.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (lon !== e.lon) begin
            $error("longitude_out: expected %0d, got %0d", e.lon, lon);
            errors++;
        end
        if (lat !== e.lat) begin
            $error("latitude_out: expected %0d, got %0d", e.lat, lat);
            errors++;
        end
        if (outside !== e.outside) begin
            $error("outside_flag: expected %0d, got %0d", e.outside, outside);
            errors++;
        end
        if (lst !== e.last) begin
            $error("last_out: expected %0d, got %0d", e.last, lst);
            errors++;
        end
    endfunction
endclass

module tb_lm_to_lon_lat_projection;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid, in_ready;
    logic signed [17:0] dir_l, dir_m;
    logic               last_in;
    logic               out_valid, out_ready;
    logic signed [19:0] longitude_out;
    logic signed [17:0] latitude_out;
    logic               outside_flag, last_out;

    sky_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_cnt;
    int sent;

    lm_to_lon_lat_projection i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .dir_l(dir_l), .dir_m(dir_m), .last_in(last_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .longitude_out(longitude_out), .latitude_out(latitude_out),
        .outside_flag(outside_flag), .last_out(last_out)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // handshakes are settled at the falling edge and taken at the next rising edge
    always @(negedge clk) begin
        bit moved;
        if (rst_n) begin
            moved = 0;
            if (in_valid && in_ready) begin
                sb.note_request(dir_l, dir_m, last_in);
                moved = 1;
            end
            if (out_valid && out_ready) begin
                sb.check_result(longitude_out, latitude_out, outside_flag, last_out);
                moved = 1;
            end
            stall_cnt <= moved ? 0 : stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic apb_write(logic is_lat, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {is_lat ? lmp_pkg::REG_LAT : lmp_pkg::REG_LON, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_centre(is_lat, value);
    endtask

    task automatic send_request(int l, int m, int lst);
        bit hs;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        dir_l    <= 18'(l);
        dir_m    <= 18'(m);
        last_in  <= 1'(lst);
        forever begin
            @(negedge clk);
            hs = in_ready;
            @(posedge clk);
            if (hs) break;
        end
        sent++;
        if (sent < 416)      tx_idle_pct = 36;
        else if (sent < 832) tx_idle_pct = 63;
        else                 tx_idle_pct = 0;
        if (sent < 416)      rx_idle_pct = 63;
        else if (sent < 832) rx_idle_pct = 36;
        else                 rx_idle_pct = 0;
    endtask

    task automatic send_random();
        int l, lim;
        if ($urandom_range(99) < 70) begin
            l = int'($urandom_range(131072)) - 65536;
            lim = int'($floor($sqrt(65536.0 * 65536.0 - real'(l) * real'(l))));
            if ($urandom_range(9) == 0)
                send_request(l, ($urandom_range(1) ? lim : -lim), int'($urandom_range(1)));
            else
                send_request(l, int'($urandom_range(2 * lim)) - lim,
                             int'($urandom_range(1)));
        end else begin
            send_request(int'($urandom), int'($urandom), int'($urandom_range(1)));
        end
    endtask

    // drain everything, then give the pipeline its full latency before touching the centre
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    initial begin
        logic [31:0] lon_set[8];
        logic [31:0] lat_set[8];
        sb = new();
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; dir_l = '0; dir_m = '0; last_in = 0;
        out_ready = 0;
        stall_cnt = 0;
        sent = 0;
        tx_idle_pct = 36;
        rx_idle_pct = 63;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset centre: corners of the fields, unit circle edges, outside points
        send_request(0, 0, 0);
        send_request(65536, 0, 0);
        send_request(-65536, 0, 1);
        send_request(0, 65536, 0);
        send_request(0, -65536, 0);
        send_request(65537, 0, 1);
        send_request(131071, 131071, 0);
        send_request(-131072, -131072, 1);
        send_request(46340, 46340, 0);
        send_request(46341, 46341, 0);
        send_request(1, 0, 0);
        send_request(-1, -65535, 1);
        drain();
        // centre near the pole puts the atan2 x term negative
        apb_write(1'b0, 32'h0003_2447);
        apb_write(1'b1, 32'h0001_9220);
        send_request(1, 0, 0);
        send_request(-1, 0, 0);
        send_request(0, 65536, 1);
        send_request(0, -65536, 0);
        send_request(-65536, 0, 0);
        send_request(30000, -40000, 1);

        lon_set = '{32'd0, 32'd205887, -32'sd205887, 32'h3FFFF, 32'h40000,
                    32'd12345, 32'hFFFF_FFFF, 32'd0};
        lat_set = '{32'd0, 32'd102944, -32'sd102944, 32'h1FFFF, 32'h20000,
                    32'd51472, 32'd70000, 32'hFFFF_FFFF};
        for (int p = 0; p < 8; p++) begin
            drain();
            if (p == 7) begin
                apb_write(1'b0, $urandom);
                apb_write(1'b1, $urandom);
            end else begin
                apb_write(1'b0, lon_set[p]);
                apb_write(1'b1, lat_set[p]);
            end
            for (int k = 0; k < 153; k++)
                send_random();
        end
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
